[src/crfc_pkg.sv]
package crfc_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned NIB_W    = 4;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [BYTE_W-1:0] CRC_POLY  = 8'hD5;
    localparam logic [BYTE_W-1:0] HI_NIBBLE = 8'hF0;
    localparam logic [BYTE_W-1:0] LO_NIBBLE = 8'h0F;

    // op codes
    localparam logic OP_BEGIN = 1'b0;
    localparam logic OP_BYTE  = 1'b1;

    // reply kinds
    localparam logic [KIND_W-1:0] KIND_HANDSHAKE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PRESS     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RELEASE   = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_CRC_ERR = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ID_ERR  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_BYTE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEVICE_NIBBLE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CMD_HANDSHAKE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CMD_PRESS       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CMD_RELEASE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OPID_HANDSHAKE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OPID_DISCONNECT = 3'd6;

    typedef struct packed {
        logic              op;
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] rx;
    } item_t;

    // one byte of crc-8, msb first, zero init
    function automatic logic [BYTE_W-1:0] crc8_byte(
        input logic [BYTE_W-1:0] crc,
        input logic [BYTE_W-1:0] data
    );
        logic [BYTE_W-1:0] c;
        c = crc ^ data;
        for (int k = 0; k < BYTE_W; k++)
        begin
            if (c[BYTE_W-1])
                c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[BYTE_W-2:0], 1'b0};
        end
        return c;
    endfunction

endpackage

[src/camera_reply_frame_checker_core.sv]
// channel   dir  handshake             payload
// input     in   in_valid / in_ready   op, reply_kind, rx_byte
// result    out  out_valid / out_ready status, osd_open
// config    in   cfg_wr_en             cfg_index, cfg_data
//
// one item per cycle sustained while the result is not stalled; a frame result
// passes from the input register to the result register after the transfer of
// the last frame byte; the crc byte update and frame compare are combinational
// rst_n clears frame state (not the stored bytes), osd flag, config, valid bits
// a stalled result holds the result register; the input register still
// takes a new item while its previous item can drain into a free result slot
module camera_reply_frame_checker_core (
    input  logic                            clk,
    input  logic                            rst_n,
    // input channel
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            op,
    input  logic [crfc_pkg::KIND_W-1:0]     reply_kind,
    input  logic [crfc_pkg::BYTE_W-1:0]     rx_byte,
    // result channel
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [crfc_pkg::STATUS_W-1:0]   status,
    output logic                            osd_open,
    // config write port
    input  logic                            cfg_wr_en,
    input  logic [crfc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [crfc_pkg::BYTE_W-1:0]     cfg_data
);
    import crfc_pkg::*;

    // configuration registers
    logic [BYTE_W-1:0] header_byte_reg;
    logic [NIB_W-1:0]  device_nibble_reg;
    logic [NIB_W-1:0]  cmd_handshake_reg;
    logic [NIB_W-1:0]  cmd_press_reg;
    logic [NIB_W-1:0]  cmd_release_reg;
    logic [NIB_W-1:0]  opid_handshake_reg;
    logic [NIB_W-1:0]  opid_disconnect_reg;

    // input register
    item_t item_reg;
    logic  item_valid_reg;

    // frame state
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic              header_seen_reg, header_seen_next;
    logic [1:0]        taken_reg, taken_next;
    logic [BYTE_W-1:0] crc_reg, crc_next;
    logic [BYTE_W-1:0] first_byte_reg, first_byte_next;
    logic [BYTE_W-1:0] second_byte_reg, second_byte_next;
    logic              flag_reg, flag_next;

    // result register
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                frame_done;

    logic              item_move;
    logic [BYTE_W-1:0] crc_upd;
    logic [1:0]        taken_inc;
    logic [1:0]        need;
    logic [NIB_W-1:0]  cmd_sel;
    logic [NIB_W-1:0]  opid;

    // the item in the input register drains once the result slot is free
    assign item_move = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !item_valid_reg || item_move;

    // result slot stays full while stalled, refills on a finished frame
    assign out_valid_next = (item_move && frame_done) || (out_valid_reg && !out_ready);

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign osd_open  = flag_reg;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_byte_reg     <= '0;
            device_nibble_reg   <= '0;
            cmd_handshake_reg   <= '0;
            cmd_press_reg       <= '0;
            cmd_release_reg     <= '0;
            opid_handshake_reg  <= '0;
            opid_disconnect_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_HEADER_BYTE:     header_byte_reg     <= cfg_data;
                REG_DEVICE_NIBBLE:   device_nibble_reg   <= cfg_data[NIB_W-1:0];
                REG_CMD_HANDSHAKE:   cmd_handshake_reg   <= cfg_data[NIB_W-1:0];
                REG_CMD_PRESS:       cmd_press_reg       <= cfg_data[NIB_W-1:0];
                REG_CMD_RELEASE:     cmd_release_reg     <= cfg_data[NIB_W-1:0];
                REG_OPID_HANDSHAKE:  opid_handshake_reg  <= cfg_data[NIB_W-1:0];
                REG_OPID_DISCONNECT: opid_disconnect_reg <= cfg_data[NIB_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (in_ready)
            item_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= {op, reply_kind, rx_byte};
    end

    // frame logic for the item in the input register
    always_comb
    begin
        // crc starts fresh on the header byte
        crc_upd   = crc8_byte(header_seen_reg ? crc_reg : '0, item_reg.rx);
        taken_inc = taken_reg + 2'd1;
        need      = (kind_reg == KIND_HANDSHAKE) ? 2'd3 : 2'd2;

        case (kind_reg)
            KIND_HANDSHAKE: cmd_sel = cmd_handshake_reg;
            KIND_RELEASE:   cmd_sel = cmd_release_reg;
            default:        cmd_sel = cmd_press_reg;  // press and the unused kind
        endcase

        opid = second_byte_reg[BYTE_W-1:NIB_W];

        kind_next        = kind_reg;
        header_seen_next = header_seen_reg;
        taken_next       = taken_reg;
        crc_next         = crc_reg;
        first_byte_next  = first_byte_reg;
        second_byte_next = second_byte_reg;
        flag_next        = flag_reg;
        status_next      = STATUS_OK;
        frame_done       = 1'b0;

        if (item_reg.op == OP_BEGIN)
        begin
            kind_next        = item_reg.kind;
            header_seen_next = 1'b0;
            taken_next       = '0;
            crc_next         = '0;
        end
        else if (!header_seen_reg)
        begin
            // hunting for the header
            if (item_reg.rx == header_byte_reg)
            begin
                header_seen_next = 1'b1;
                taken_next       = '0;
                crc_next         = crc_upd;
            end
        end
        else
        begin
            crc_next   = crc_upd;
            taken_next = taken_inc;
            if (taken_reg == 2'd0)
                first_byte_next = item_reg.rx;
            else if (taken_reg == 2'd1)
                second_byte_next = item_reg.rx;

            if (taken_inc == need)
            begin
                frame_done = 1'b1;
                // first byte is always stored before completion
                if (crc_upd != '0)
                    status_next = STATUS_CRC_ERR;
                else if (first_byte_next != {device_nibble_reg, cmd_sel})
                    status_next = STATUS_ID_ERR;
                else
                begin
                    status_next = STATUS_OK;
                    if (kind_reg == KIND_HANDSHAKE &&
                        (second_byte_next & LO_NIBBLE) == 8'h01)
                    begin
                        opid = second_byte_next[BYTE_W-1:NIB_W];
                        if (opid == opid_handshake_reg)
                            flag_next = 1'b1;
                        else if (opid == opid_disconnect_reg)
                            flag_next = 1'b0;
                    end
                end
                header_seen_next = 1'b0;
                taken_next       = '0;
                crc_next         = '0;
            end
        end
    end

    // frame state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg        <= KIND_HANDSHAKE;
            header_seen_reg <= 1'b0;
            taken_reg       <= '0;
            crc_reg         <= '0;
            flag_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (item_move)
            begin
                kind_reg        <= kind_next;
                header_seen_reg <= header_seen_next;
                taken_reg       <= taken_next;
                crc_reg         <= crc_next;
                if (frame_done)
                    flag_reg <= flag_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_move)
        begin
            first_byte_reg  <= first_byte_next;
            second_byte_reg <= second_byte_next;
            if (frame_done)
                status_reg <= status_next;
        end
    end

endmodule

[src/crfc_checker.sv]
module crfc_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [crfc_pkg::STATUS_W-1:0]   status,
    input logic                            osd_open
);
    import crfc_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(osd_open))
        else $error("result changed while stalled");

    // only the three defined status codes leave the block
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == STATUS_OK || status == STATUS_CRC_ERR ||
                       status == STATUS_ID_ERR))
        else $error("undefined status code");

    // input backpressure only comes from a stalled result
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without a stalled result");

endmodule

bind camera_reply_frame_checker_core crfc_checker u_crfc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .osd_open  (osd_open)
);
